@@ hdl/tkpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tkpq_pkg: shared types and constants of the three-key priority queue
// entry layout, cell commands, status codes and the ranking function
// ----------------------------------------------------------------------------
package tkpq_pkg;

   localparam int DEPTH   = 256;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int ID_W    = 20;
   localparam int KEY_W   = 16;
   localparam int HELD_W  = 9;

   // request action codes
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_PUSHED  = 2'd0,
      ST_POPPED  = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_DROPPED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_PUSH = 2'd1,
      CELL_POP  = 2'd2
   } cell_op_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] bid;
      logic [KEY_W-1:0] engagement;
      logic [KEY_W-1:0] budget;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   entry;
   } cell_cmd_type;

   // true if a ranks above b: keys first, lower id wins a full tie
   function automatic logic ranks_above(entry_type a, entry_type b);
      logic [3*KEY_W-1:0] ka;
      logic [3*KEY_W-1:0] kb;
      ka = {a.bid, a.engagement, a.budget};
      kb = {b.bid, b.engagement, b.budget};
      if (ka != kb) begin
         return ka > kb;
      end
      return a.id < b.id;
   endfunction

endpackage

@@ hdl/tkpq_cell.sv @@
// ----------------------------------------------------------------------------
// tkpq_cell: one slot of the sorted queue
// holds one entry, compares it with a pushed word, shifts up or down
// ----------------------------------------------------------------------------
module tkpq_cell (
   input  logic                  clock,
   input  tkpq_pkg::cell_cmd_type cmd,
   input  logic                  own_valid,
   input  logic                  prev_beats,
   input  tkpq_pkg::entry_type   prev_entry,
   input  tkpq_pkg::entry_type   next_entry,
   output tkpq_pkg::entry_type   entry,
   output logic                  beats
);

   tkpq_pkg::entry_type entry_ff;
   tkpq_pkg::entry_type entry_in;

   // pushed word belongs at or above this slot
   assign beats = !own_valid || tkpq_pkg::ranks_above(cmd.entry, entry_ff);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         tkpq_pkg::CELL_PUSH: begin
            if (beats) begin
               entry_in = prev_beats ? prev_entry : cmd.entry;
            end
         end
         tkpq_pkg::CELL_POP: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ hdl/three_key_priority_queue.sv @@
// ----------------------------------------------------------------------------
// three_key_priority_queue: max priority queue of ad entries
// sorted chain of cells ranked by bid, engagement, budget, then lower id
// ----------------------------------------------------------------------------
// A request word is accepted in every cycle in which the response register is
// empty or being drained, so one push or pop per cycle is sustained, and its
// response appears in the cycle after acceptance. The rate is set by the chain of
// DEPTH cells: every cell compares a pushed word with its own entry in the same
// cycle and shifts one place, so the best entry always sits in cell 0 and a
// pop reads it there. A push onto a full queue is dropped with status 3, a pop
// on an empty queue returns status 2, and every response carries the number of
// entries held after the access. Cell contents need no reset; occupancy comes
// from the fill count alone.
module three_key_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [19:0] req_ad_id,
   input  logic [15:0] req_bid,
   input  logic [15:0] req_engagement,
   input  logic [15:0] req_budget,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [19:0] rsp_out_id,
   output logic [15:0] rsp_out_bid,
   output logic [15:0] rsp_out_engagement,
   output logic [15:0] rsp_out_budget,
   output logic [8:0]  rsp_entries_held
);

   localparam int DEPTH   = tkpq_pkg::DEPTH;
   localparam int COUNT_W = tkpq_pkg::COUNT_W;

   // fill count and response register
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   tkpq_pkg::status_type   status_ff;
   tkpq_pkg::status_type   status_in;
   tkpq_pkg::entry_type    out_ff;
   tkpq_pkg::entry_type    out_in;
   logic [COUNT_W-1:0]     held_ff;

   logic                   req_fire;
   logic                   is_full;
   logic                   is_empty;
   tkpq_pkg::cell_cmd_type cmd;
   tkpq_pkg::entry_type    req_entry;

   // chain wiring
   tkpq_pkg::entry_type    cell_entry [DEPTH];
   logic                   cell_beats [DEPTH];

   assign req_entry = '{id: req_ad_id, bid: req_bid, engagement: req_engagement,
                        budget: req_budget};

   // response register frees up as the word leaves
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_full   = (count_ff == COUNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      out_in       = out_ff;
      cmd.op       = tkpq_pkg::CELL_HOLD;
      cmd.entry    = req_entry;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         out_in       = '0;
         if (req_action == tkpq_pkg::ACT_PUSH) begin
            if (is_full) begin
               status_in = tkpq_pkg::ST_DROPPED;
            end else begin
               status_in = tkpq_pkg::ST_PUSHED;
               cmd.op    = tkpq_pkg::CELL_PUSH;
               count_in  = count_ff + COUNT_W'(1);
            end
         end else begin
            if (is_empty) begin
               status_in = tkpq_pkg::ST_EMPTY;
            end else begin
               // best entry always sits at the head of the chain
               status_in = tkpq_pkg::ST_POPPED;
               out_in    = cell_entry[0];
               cmd.op    = tkpq_pkg::CELL_POP;
               count_in  = count_ff - COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds while the response waits
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      out_ff    <= out_in;
      if (req_fire) begin
         held_ff <= count_in;
      end
   end

   // sorted cell chain, cell 0 holds the best entry
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      tkpq_pkg::entry_type prev_entry;
      tkpq_pkg::entry_type next_entry;
      logic                prev_beats;
      logic                own_valid;

      assign own_valid = (count_ff > COUNT_W'(i));

      if (i == 0) begin : g_head
         assign prev_entry = req_entry;
         assign prev_beats = 1'b0;
      end else begin : g_body
         assign prev_entry = cell_entry[i-1];
         assign prev_beats = cell_beats[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_entry = cell_entry[i];
      end else begin : g_link
         assign next_entry = cell_entry[i+1];
      end

      tkpq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .own_valid  (own_valid),
         .prev_beats (prev_beats),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .beats      (cell_beats[i])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_id         = out_ff.id;
   assign rsp_out_bid        = out_ff.bid;
   assign rsp_out_engagement = out_ff.engagement;
   assign rsp_out_budget     = out_ff.budget;
   assign rsp_entries_held   = tkpq_pkg::HELD_W'(held_ff);

   // occupancy never passes the chain length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("fill count beyond depth");

   // pop on empty reports empty status
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_action == tkpq_pkg::ACT_POP && is_empty
      |=> rsp_status == tkpq_pkg::ST_EMPTY && rsp_valid)
      else $error("pop on empty not reported");

   // accepted push below full grows the count by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_action == tkpq_pkg::ACT_PUSH && !is_full
      |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("push did not grow count");

   // no new word taken while a response is stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request accepted over stalled response");

endmodule
